>>> sv/afd_pkg.sv
package afd_pkg;

   localparam int MAX_POSITION_DEFAULT = 128;

   localparam logic [7:0] FLAG_BYTE   = 8'h7E;
   localparam logic [7:0] ESCAPE_BYTE = 8'h7D;
   localparam logic [7:0] ESCAPE_XOR  = 8'h20;
   localparam logic [7:0] SUM_GOOD    = 8'hFF;

   typedef enum logic [2:0] {
      EV_DATA       = 3'd0,
      EV_FRAME_GOOD = 3'd1,
      EV_CSUM_FAIL  = 3'd2,
      EV_UNEXP_START = 3'd3,
      EV_TOO_LONG   = 3'd4
   } event_kind_type;

   typedef struct packed {
      event_kind_type event_kind;
      logic [7:0]     data_byte;
      logic [6:0]     byte_index;
      logic [7:0]     api_id;
      logic [6:0]     frame_length;
      logic [7:0]     checksum_byte;
   } result_type;

endpackage

>>> sv/afd_in_stage.sv
module afd_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] out_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;

   assign req_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (req_ready) begin
         valid_in = req_valid;
         if (req_valid) begin
            byte_in = req_rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;

endmodule

>>> sv/afd_parser.sv
module afd_parser #(
   parameter int MAX_POSITION = afd_pkg::MAX_POSITION_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 escaped_mode,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [7:0]           in_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output afd_pkg::result_type  rsp_result
);

   localparam int PW = $clog2(MAX_POSITION + 2);
   localparam int EW = PW + 7;

   logic [PW-1:0]       pos_ff, pos_in;
   logic                esc_ff, esc_in;
   logic [7:0]          sum_ff, sum_in;
   logic [15:0]         len_ff, len_in;
   logic [7:0]          api_ff, api_in;
   logic                rsp_valid_ff, rsp_valid_in;
   afd_pkg::result_type res_ff, res_in;

   logic                advance;
   logic                emit;
   afd_pkg::result_type res_new;
   logic [7:0]          b;
   logic [EW-1:0]       offset;

   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign advance  = in_valid && in_ready;
   assign b        = esc_ff ? (in_byte ^ afd_pkg::ESCAPE_XOR) : in_byte;
   assign offset   = {7'b0, pos_ff} - EW'(4);

   always_comb begin
      pos_in  = pos_ff;
      esc_in  = esc_ff;
      sum_in  = sum_ff;
      len_in  = len_ff;
      api_in  = api_ff;
      emit    = 1'b0;
      res_new = '0;
      res_new.api_id = api_ff;
      if (pos_ff != '0 && in_byte == afd_pkg::FLAG_BYTE && escaped_mode) begin
         emit               = 1'b1;
         res_new.event_kind = afd_pkg::EV_UNEXP_START;
         pos_in             = '0;
         esc_in             = 1'b0;
         sum_in             = '0;
      end else if (pos_ff != '0 && in_byte == afd_pkg::ESCAPE_BYTE) begin
         esc_in = 1'b1;
      end else begin
         esc_in = 1'b0;
         if (pos_ff >= PW'(3)) begin
            sum_in = sum_ff + b;
         end
         if (pos_ff == PW'(0)) begin
            if (b == afd_pkg::FLAG_BYTE) begin
               pos_in = PW'(1);
               len_in = '0;
               api_in = '0;
            end
         end else if (pos_ff == PW'(1)) begin
            len_in = {b, len_ff[7:0]};
            pos_in = PW'(2);
         end else if (pos_ff == PW'(2)) begin
            len_in = {len_ff[15:8], b};
            pos_in = PW'(3);
         end else if (pos_ff == PW'(3)) begin
            api_in = b;
            pos_in = PW'(4);
         end else if (pos_ff > PW'(MAX_POSITION)) begin
            emit               = 1'b1;
            res_new.event_kind = afd_pkg::EV_TOO_LONG;
            pos_in             = '0;
            sum_in             = '0;
         end else if (17'(pos_ff) == {1'b0, len_ff} + 17'd3) begin
            emit                  = 1'b1;
            res_new.event_kind    = (sum_in == afd_pkg::SUM_GOOD) ?
                                    afd_pkg::EV_FRAME_GOOD : afd_pkg::EV_CSUM_FAIL;
            res_new.frame_length  = offset[6:0];
            res_new.checksum_byte = b;
            pos_in                = '0;
            sum_in                = '0;
         end else begin
            emit               = 1'b1;
            res_new.event_kind = afd_pkg::EV_DATA;
            res_new.data_byte  = b;
            res_new.byte_index = offset[6:0];
            pos_in             = pos_ff + PW'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      res_in       = res_ff;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
         res_in       = res_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         esc_ff       <= 1'b0;
         sum_ff       <= '0;
         len_ff       <= '0;
         api_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            pos_ff <= pos_in;
            esc_ff <= esc_in;
            sum_ff <= sum_in;
            len_ff <= len_in;
            api_ff <= api_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = res_ff;

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PW'(MAX_POSITION + 1))
      else $error("position beyond limit");

   a_esc_in_frame: assert property (@(posedge clock) disable iff (reset)
      esc_ff |-> pos_ff != '0)
      else $error("escape pending while hunting");

   a_sum_clear_hunt: assert property (@(posedge clock) disable iff (reset)
      pos_ff == '0 |-> sum_ff == '0)
      else $error("checksum not cleared while hunting");

   a_error_restart: assert property (@(posedge clock) disable iff (reset)
      (advance && emit && (res_new.event_kind == afd_pkg::EV_UNEXP_START ||
                           res_new.event_kind == afd_pkg::EV_TOO_LONG))
      |=> pos_ff == '0 && !esc_ff)
      else $error("no restart after error");

endmodule

>>> sv/api_frame_deframer_core.sv
// Channel   Direction  Handshake               Word
// req_      in         req_valid / req_ready   rx_byte
// rsp_      out        rsp_valid / rsp_ready   event, data, index, id, length, checksum
// csr_      in         csr_valid / csr_ready   escaped_mode
//
// One word per cycle sustained while results are taken; from accept to result a word
// passes the input register, then the parser update into the result register.
// Synchronous active-high reset: hunting for start, escaped_mode set.
// A held result stalls the parser and then the input register; csr is always ready.
module api_frame_deframer_core #(
   parameter int MAX_POSITION = afd_pkg::MAX_POSITION_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_event_kind,
   output logic [7:0] rsp_data_byte,
   output logic [6:0] rsp_byte_index,
   output logic [7:0] rsp_api_id,
   output logic [6:0] rsp_frame_length,
   output logic [7:0] rsp_checksum_byte,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_wdata
);

   logic                escaped_mode_ff, escaped_mode_in;
   logic                stage_valid;
   logic                stage_ready;
   logic [7:0]          stage_byte;
   afd_pkg::result_type result;

   assign csr_ready       = 1'b1;
   assign escaped_mode_in = (csr_valid && csr_ready) ? csr_wdata : escaped_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         escaped_mode_ff <= 1'b1;
      end else begin
         escaped_mode_ff <= escaped_mode_in;
      end
   end

   afd_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .out_valid   (stage_valid),
      .out_ready   (stage_ready),
      .out_byte    (stage_byte)
   );

   afd_parser #(
      .MAX_POSITION (MAX_POSITION)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .escaped_mode (escaped_mode_ff),
      .in_valid     (stage_valid),
      .in_ready     (stage_ready),
      .in_byte      (stage_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_result   (result)
   );

   assign rsp_event_kind    = result.event_kind;
   assign rsp_data_byte     = result.data_byte;
   assign rsp_byte_index    = result.byte_index;
   assign rsp_api_id        = result.api_id;
   assign rsp_frame_length  = result.frame_length;
   assign rsp_checksum_byte = result.checksum_byte;

endmodule

>>> bench/api_frame_deframer_core_test.sv
`timescale 1ns / 1ps

module api_frame_deframer_core_test;

   localparam int LIMIT_POS   = afd_pkg::MAX_POSITION_DEFAULT;
   localparam int CYCLE_LIMIT = 300000;

   typedef enum {FRAME_OK, FRAME_BAD_SUM, FRAME_STRAY_START} frame_fault_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_event_kind;
   logic [7:0] rsp_data_byte;
   logic [6:0] rsp_byte_index;
   logic [7:0] rsp_api_id;
   logic [6:0] rsp_frame_length;
   logic [7:0] rsp_checksum_byte;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_wdata = 1'b0;

   api_frame_deframer_core #(.MAX_POSITION(LIMIT_POS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_event_kind(rsp_event_kind),
      .rsp_data_byte(rsp_data_byte),
      .rsp_byte_index(rsp_byte_index),
      .rsp_api_id(rsp_api_id),
      .rsp_frame_length(rsp_frame_length),
      .rsp_checksum_byte(rsp_checksum_byte),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // parser copy
   logic        esc_mode = 1'b1;
   int          frm_pos = 0;
   logic        esc_pend = 1'b0;
   logic [7:0]  csum = 8'h00;
   logic [15:0] len_field = 16'h0000;
   logic [7:0]  frm_api = 8'h00;

   afd_pkg::result_type events_due[$];
   logic [7:0]  rx_pending[$];
   logic [7:0]  payload[$];

   logic tx_mode = 1'b1;
   int   gap_max = 3, stall_max = 3;
   int   req_gap = 0, rsp_wait = 0;
   logic req_took = 1'b0, csr_taken = 1'b0;
   int   n_fed = 0, n_accepted = 0, n_framed = 0, n_events = 0;
   int   n_bad = 0, n_cycles = 0, n_mode_writes = 0;
   int   kind_seen[5] = '{default: 0};

   function automatic void restart_hunt();
      frm_pos  = 0;
      esc_pend = 1'b0;
      csum     = 8'h00;
   endfunction

   function automatic bit deframe_byte(input logic [7:0] rx,
                                       output afd_pkg::result_type ev);
      logic [7:0] b;
      b  = rx;
      ev = '0;
      if (frm_pos > 0 && b == afd_pkg::FLAG_BYTE && esc_mode) begin
         ev.event_kind = afd_pkg::EV_UNEXP_START;
         ev.api_id     = frm_api;
         restart_hunt();
         return 1'b1;
      end
      if (frm_pos > 0 && b == afd_pkg::ESCAPE_BYTE) begin
         esc_pend = 1'b1;
         return 1'b0;
      end
      if (esc_pend) begin
         b        = b ^ afd_pkg::ESCAPE_XOR;
         esc_pend = 1'b0;
      end
      if (frm_pos >= 3) csum = csum + b;
      case (frm_pos)
         0: begin
            if (b == afd_pkg::FLAG_BYTE) begin
               frm_pos   = 1;
               len_field = 16'h0000;
               frm_api   = 8'h00;
            end
            return 1'b0;
         end
         1: begin
            len_field[15:8] = b;
            frm_pos = 2;
            return 1'b0;
         end
         2: begin
            len_field[7:0] = b;
            frm_pos = 3;
            return 1'b0;
         end
         3: begin
            frm_api = b;
            frm_pos = 4;
            return 1'b0;
         end
         default: ;
      endcase
      ev.api_id = frm_api;
      if (frm_pos > LIMIT_POS) begin
         ev.event_kind = afd_pkg::EV_TOO_LONG;
         restart_hunt();
         return 1'b1;
      end
      if (frm_pos == int'(len_field) + 3) begin
         ev.event_kind    = (csum == afd_pkg::SUM_GOOD) ? afd_pkg::EV_FRAME_GOOD
                                                        : afd_pkg::EV_CSUM_FAIL;
         ev.frame_length  = 7'(frm_pos - 4);
         ev.checksum_byte = b;
         restart_hunt();
         return 1'b1;
      end
      ev.event_kind = afd_pkg::EV_DATA;
      ev.data_byte  = b;
      ev.byte_index = 7'(frm_pos - 4);
      frm_pos++;
      return 1'b1;
   endfunction

   // sender and receiver, driven on the falling edge
   always @(negedge clock) begin : drive
      logic nxt_valid;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         nxt_valid = req_valid && !req_took;
         if (!nxt_valid) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (rx_pending.size() > 0) begin
               req_rx_byte <= rx_pending.pop_front();
               n_fed++;
               nxt_valid = 1'b1;
               req_gap   = $urandom_range(0, gap_max);
            end
         end
         req_valid <= nxt_valid;
         if (rsp_wait > 0) begin
            rsp_ready <= 1'b0;
            rsp_wait--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watch
      afd_pkg::result_type got, want;
      if (reset) begin
         restart_hunt();
         esc_mode  = 1'b1;
         len_field = 16'h0000;
         frm_api   = 8'h00;
         req_took  = 1'b0;
         csr_taken = 1'b0;
         rsp_wait  = 0;
         events_due.delete();
      end else begin
         req_took  = req_valid && req_ready;
         csr_taken = csr_valid && csr_ready;
         if (rsp_valid && rsp_ready) begin
            got = afd_pkg::result_type'({rsp_event_kind, rsp_data_byte, rsp_byte_index,
                                         rsp_api_id, rsp_frame_length, rsp_checksum_byte});
            n_events++;
            if (rsp_event_kind < 5) kind_seen[rsp_event_kind]++;
            if (events_due.size() == 0) begin
               n_bad++;
               if (n_bad <= 10)
                  $display("%0t: word out with none due: kind %0d data %h idx %0d", $realtime,
                           rsp_event_kind, rsp_data_byte, rsp_byte_index);
            end else begin
               want = events_due.pop_front();
               if (got.event_kind !== want.event_kind || got.data_byte !== want.data_byte ||
                   got.byte_index !== want.byte_index || got.api_id !== want.api_id ||
                   got.frame_length !== want.frame_length ||
                   got.checksum_byte !== want.checksum_byte) begin
                  n_bad++;
                  if (n_bad <= 10)
                     $display({"%0t: mismatch exp/got kind %0d/%0d data %h/%h idx %0d/%0d ",
                               "id %h/%h len %0d/%0d sum %h/%h"}, $realtime,
                              want.event_kind, got.event_kind, want.data_byte, got.data_byte,
                              want.byte_index, got.byte_index, want.api_id, got.api_id,
                              want.frame_length, got.frame_length,
                              want.checksum_byte, got.checksum_byte);
               end
            end
            rsp_wait = $urandom_range(0, stall_max);
         end
         if (req_took) begin
            n_accepted++;
            if (deframe_byte(req_rx_byte, want)) events_due.push_back(want);
         end
         if (csr_taken) esc_mode = csr_wdata;
      end
   end

   always @(posedge clock) begin
      n_cycles++;
      if (n_cycles > CYCLE_LIMIT) begin
         $display("api_frame_deframer_core_test: errors");
         $finish;
      end
   end

   function automatic logic [7:0] pick_byte();
      if ($urandom_range(0, 7) == 0)
         return $urandom_range(0, 1) ? afd_pkg::FLAG_BYTE : afd_pkg::ESCAPE_BYTE;
      return 8'($urandom);
   endfunction

   // one byte after the start, escaped where needed and now and then where not
   task automatic put_framed(input logic [7:0] b);
      logic [7:0] x;
      x = b ^ afd_pkg::ESCAPE_XOR;
      if (b == afd_pkg::ESCAPE_BYTE || (b == afd_pkg::FLAG_BYTE && tx_mode) ||
          ($urandom_range(0, 9) == 0 && x != afd_pkg::FLAG_BYTE &&
           x != afd_pkg::ESCAPE_BYTE)) begin
         if ($urandom_range(0, 15) == 0) rx_pending.push_back(afd_pkg::ESCAPE_BYTE);
         rx_pending.push_back(afd_pkg::ESCAPE_BYTE);
         rx_pending.push_back(x);
      end else begin
         rx_pending.push_back(b);
      end
      n_framed++;
   endtask

   task automatic send_frame(input logic [7:0] api, input frame_fault_type fault);
      logic [7:0]  words[$];
      logic [7:0]  sum;
      logic [15:0] len;
      int          cut;
      sum = api;
      foreach (payload[i]) sum += payload[i];
      sum = afd_pkg::SUM_GOOD - sum;
      if (fault == FRAME_BAD_SUM) sum += 8'($urandom_range(1, 255));
      len   = 16'(payload.size() + 1);
      words = {len[15:8], len[7:0], api, payload, sum};
      cut   = (fault == FRAME_STRAY_START) ? $urandom_range(0, words.size() - 1) : -1;
      rx_pending.push_back(afd_pkg::FLAG_BYTE);
      foreach (words[i]) begin
         if (i == cut) begin
            if ($urandom_range(0, 1)) rx_pending.push_back(afd_pkg::ESCAPE_BYTE);
            rx_pending.push_back(afd_pkg::FLAG_BYTE);
         end
         put_framed(words[i]);
      end
   endtask

   // length that never matches an end: runs until the frame is too long
   task automatic send_runaway(input logic [15:0] len);
      rx_pending.push_back(afd_pkg::FLAG_BYTE);
      put_framed(len[15:8]);
      put_framed(len[7:0]);
      repeat (LIMIT_POS - 1) put_framed(pick_byte());
   endtask

   task automatic drain();
      do @(negedge clock);
      while (rx_pending.size() != 0 || n_fed != n_accepted || events_due.size() != 0);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_mode(input logic m);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= m;
      do @(negedge clock); while (!csr_taken);
      csr_valid <= 1'b0;
      tx_mode = m;
      n_mode_writes++;
   endtask

   initial begin : stimulus
      int pick, n, mark;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // escaped mode from reset: noise while hunting, extremes, escapes, errors
      rx_pending = {rx_pending, 8'h00, 8'hFF, afd_pkg::ESCAPE_BYTE};
      payload = {8'hFF};
      send_frame(8'h00, FRAME_OK);
      payload = {8'h00, afd_pkg::FLAG_BYTE, afd_pkg::ESCAPE_BYTE, 8'h11, 8'h13};
      send_frame(8'hFF, FRAME_OK);
      payload = {};
      send_frame(8'h5A, FRAME_BAD_SUM);
      // start while an escape is pending, then a byte that must be ignored
      rx_pending = {rx_pending, afd_pkg::FLAG_BYTE, 8'h00, 8'h03, 8'h10,
                    afd_pkg::ESCAPE_BYTE, afd_pkg::FLAG_BYTE, 8'h55};
      // escape on escape, data 7e
      rx_pending = {rx_pending, afd_pkg::FLAG_BYTE, 8'h00, 8'h02, 8'hA5,
                    afd_pkg::ESCAPE_BYTE, afd_pkg::ESCAPE_BYTE, 8'h5E, 8'hDC};
      drain();

      // plain mode: raw start bytes are data
      write_mode(1'b0);
      payload = {afd_pkg::FLAG_BYTE, afd_pkg::FLAG_BYTE, afd_pkg::ESCAPE_BYTE};
      send_frame(afd_pkg::FLAG_BYTE, FRAME_OK);
      payload = {8'h01, 8'h02};
      send_frame(8'h11, FRAME_STRAY_START);
      drain();

      // longest frame and an overrun at the end position just past the limit, no idling
      write_mode(1'b1);
      gap_max   = 0;
      stall_max = 0;
      payload = {};
      repeat (LIMIT_POS - 4) payload.push_back(pick_byte());
      send_frame(pick_byte(), FRAME_OK);
      send_runaway(16'(LIMIT_POS - 2));
      drain();

      for (int p = 0; p < 4; p++) begin
         gap_max   = (p % 2) ? 0 : 3;
         stall_max = (p < 2) ? 3 : 0;
         write_mode(1'(p % 2));
         mark = n_framed;
         while (n_framed - mark < 16) begin
            pick = $urandom_range(0, 99);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 30) : $urandom_range(0, 6);
            payload = {};
            repeat (n) payload.push_back(pick_byte());
            if (pick < 65) send_frame(pick_byte(), FRAME_OK);
            else if (pick < 78) send_frame(pick_byte(), FRAME_BAD_SUM);
            else if (pick < 88) send_frame(pick_byte(), FRAME_STRAY_START);
            else if (pick < 99) repeat ($urandom_range(1, 4)) rx_pending.push_back(8'($urandom));
            else send_runaway($urandom_range(0, 1) ? 16'h0000
                                                   : 16'($urandom_range(LIMIT_POS - 2, 65535)));
         end
         drain();
      end

      $display({"fed %0d words, checked %0d events: %0d data, %0d good, %0d bad sum, ",
                "%0d stray start, %0d overrun"},
               n_accepted, n_events, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
               kind_seen[4]);
      $display("escaped mode written %0d times across both settings, with and without idling",
               n_mode_writes);
      if (n_bad == 0 && events_due.size() == 0) begin
         $display("api_frame_deframer_core_test: clean");
      end else begin
         $display("api_frame_deframer_core_test: errors");
      end
      $finish;
   end

endmodule
